/* hw/rtl/rwc_pkg.sv */
// shared types and constants for the tcp reno window control block
package rwc_pkg;

   // command codes of an input item
   localparam logic [1:0] CMD_ACK     = 2'd0;
   localparam logic [1:0] CMD_TIMEOUT = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // congestion phase codes
   localparam logic [1:0] PH_SLOW_START    = 2'd0;
   localparam logic [1:0] PH_AVOIDANCE     = 2'd1;
   localparam logic [1:0] PH_FAST_RECOVERY = 2'd2;

   // register byte addresses
   localparam logic [3:0] ADDR_MSS       = 4'h0;
   localparam logic [3:0] ADDR_INIT_THR  = 4'h4;
   localparam logic [3:0] ADDR_START_SEQ = 4'h8;

   // reset values
   localparam logic [15:0] MSS_RESET       = 16'd1024;
   localparam logic [31:0] INIT_THR_RESET  = 32'd65536;
   localparam logic [31:0] START_SEQ_RESET = 32'd0;
   localparam logic [1:0]  DUP_LIMIT       = 2'd3;

   // one input item
   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] ack_number;
      logic        checksum_ok;
   } req_data_type;

   // one result item
   typedef struct packed {
      logic [31:0] window_bytes;
      logic [31:0] threshold_bytes;
      logic [1:0]  phase;
      logic        resend_oldest;
      logic        was_duplicate;
   } rsp_data_type;

endpackage

/* hw/rtl/tcp_reno_window_control.sv */
// top level of the tcp reno congestion window control block
//
//  channel   direction  handshake             payload
//  req       in         req_valid/req_stall   rwc_pkg::req_data_type
//  rsp       out        rsp_valid/rsp_stall   rwc_pkg::rsp_data_type
//  csr       in/out     psel/penable/pready   mss, initial_threshold, start_seq
//
// an item passes through accept, execute and result load; a new ack in
// congestion avoidance also waits for the serial divider, which forms the product
// mss*mss, produces one quotient bit per cycle and then signals done.
// one item is worked on at a time; req_stall is high until the result is loaded
// into the output register, which waits there while rsp_stall is high.
// reset is synchronous and restores the register and window state reset values.
module tcp_reno_window_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rwc_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rwc_pkg::rsp_data_type rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import rwc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_DIV  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   // saturating window add
   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [32:0] b);
      logic [33:0] s;
      s = {2'b00, a} + {1'b0, b};
      return (s[33:32] != 2'b00) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   state_type    state_ff, state_in;
   logic [15:0]  mss_ff;
   logic [31:0]  init_thr_ff;
   logic [31:0]  start_seq_ff;
   logic [31:0]  window_ff, window_in;
   logic [31:0]  thr_ff, thr_in;
   logic [1:0]   phase_ff, phase_in;
   logic [1:0]   dup_ff, dup_in;
   logic [31:0]  acked_ff, acked_in;
   logic         resend_ff, resend_in;
   logic         isdup_ff, isdup_in;
   req_data_type item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff;
   logic         req_accept;
   logic         out_free;
   logic         csr_write;
   logic         div_start;
   logic         div_done;
   logic [31:0]  div_quo;
   logic [31:0]  div_dvs;
   logic [1:0]   dup_cnt;
   logic [31:0]  half_win;

   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign req_stall  = (state_ff != S_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_write  = psel && penable && pwrite;
   assign pready     = 1'b1;

   // register read mux
   always_comb begin
      unique case (paddr)
         ADDR_MSS:       prdata = {16'd0, mss_ff};
         ADDR_INIT_THR:  prdata = init_thr_ff;
         ADDR_START_SEQ: prdata = start_seq_ff;
         default:        prdata = '0;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mss_ff       <= MSS_RESET;
         init_thr_ff  <= INIT_THR_RESET;
         start_seq_ff <= START_SEQ_RESET;
      end else if (csr_write) begin
         unique case (paddr)
            ADDR_MSS:       mss_ff       <= pwdata[15:0];
            ADDR_INIT_THR:  init_thr_ff  <= pwdata;
            ADDR_START_SEQ: start_seq_ff <= pwdata;
            default:        ;
         endcase
      end
   end

   // avoidance step divider, zero window taken as one
   assign div_dvs = (window_ff == 32'd0) ? 32'd1 : window_ff;

   rwc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .mss      (mss_ff),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign dup_cnt  = (dup_ff < DUP_LIMIT) ? dup_ff + 2'd1 : dup_ff;
   assign half_win = {1'b0, window_ff[31:1]};

   // event sequencer and window state update
   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      thr_in       = thr_ff;
      phase_in     = phase_ff;
      dup_in       = dup_ff;
      acked_in     = acked_ff;
      resend_in    = resend_ff;
      isdup_in     = isdup_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_start    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in  = S_EXEC;
               resend_in = 1'b0;
               isdup_in  = 1'b0;
            end
         end
         S_EXEC: begin
            state_in = S_OUT;
            priority if (item_ff.cmd == CMD_ACK && item_ff.checksum_ok) begin
               if (item_ff.ack_number <= acked_ff) begin
                  // duplicate ack
                  isdup_in = 1'b1;
                  if (phase_ff == PH_FAST_RECOVERY) begin
                     window_in = sat_add(window_ff, 33'(mss_ff));
                  end else begin
                     dup_in = dup_cnt;
                     if (dup_cnt == DUP_LIMIT) begin
                        thr_in    = half_win;
                        window_in = sat_add(half_win, 33'(mss_ff) * 33'd3);
                        phase_in  = PH_FAST_RECOVERY;
                        resend_in = 1'b1;
                     end
                  end
               end else begin
                  // new ack
                  acked_in = item_ff.ack_number;
                  dup_in   = '0;
                  unique case (phase_ff)
                     PH_SLOW_START: window_in = sat_add(window_ff, 33'(mss_ff));
                     PH_AVOIDANCE: begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                     default: begin
                        window_in = thr_ff;
                        phase_in  = PH_AVOIDANCE;
                     end
                  endcase
               end
               // leave slow start once the window reaches the threshold
               if (phase_in == PH_SLOW_START && window_in >= thr_in) begin
                  phase_in = PH_AVOIDANCE;
               end
            end else if (item_ff.cmd == CMD_TIMEOUT) begin
               thr_in    = half_win;
               window_in = {16'd0, mss_ff};
               dup_in    = '0;
               phase_in  = PH_SLOW_START;
               resend_in = 1'b1;
            end else if (item_ff.cmd == CMD_RESTART) begin
               window_in = {16'd0, mss_ff};
               thr_in    = init_thr_ff;
               acked_in  = start_seq_ff;
               dup_in    = '0;
               phase_in  = PH_SLOW_START;
            end else begin
               // ignored ack or unused command
            end
         end
         S_DIV: begin
            if (div_done) begin
               window_in = sat_add(window_ff, {1'b0, div_quo});
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control and window state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= 32'(MSS_RESET);
         thr_ff       <= INIT_THR_RESET;
         phase_ff     <= PH_SLOW_START;
         dup_ff       <= '0;
         acked_ff     <= START_SEQ_RESET;
         resend_ff    <= 1'b0;
         isdup_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         thr_ff       <= thr_in;
         phase_ff     <= phase_in;
         dup_ff       <= dup_in;
         acked_ff     <= acked_in;
         resend_ff    <= resend_in;
         isdup_ff     <= isdup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input item and result payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_data;
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_data_ff.window_bytes    <= window_ff;
         rsp_data_ff.threshold_bytes <= thr_ff;
         rsp_data_ff.phase           <= phase_ff;
         rsp_data_ff.resend_oldest   <= resend_ff;
         rsp_data_ff.was_duplicate   <= isdup_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/rwc_div.sv */
// multiply-then-divide unit: floor(mss*mss/divisor), one quotient bit per cycle
module rwc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] mss,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   import rwc_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] trial;
   logic [32:0] diff;

   // one restoring step: shift in the next dividend bit and try a subtract
   always_comb begin
      trial = {rem_ff, quo_ff[31]};
      diff  = trial - {1'b0, dvs_ff};
   end

   // sequencer of the iterations
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = 32'(mss) * 32'(mss);
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (diff[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end else begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
